FILE: rtl/core/big5gf_pkg.sv
// Shared types and constants for the Big5 glyph fetch sequencer.
package big5gf_pkg;

   // Font codes on the result channel
   localparam logic [1:0] FONT_ASCII    = 2'd0;
   localparam logic [1:0] FONT_STANDARD = 2'd1;
   localparam logic [1:0] FONT_SPECIAL  = 2'd2;

   // Bitmap lengths in bytes
   localparam logic [4:0] ASCII_BYTES = 5'd15;
   localparam logic [4:0] WIDE_BYTES  = 5'd30;

   // Byte codes and ranges
   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
   localparam logic [7:0] BYTE_HIGH_CTRL = 8'h80;
   localparam logic [7:0] LEAD_FIRST     = 8'hA0;
   localparam logic [7:0] LEAD_SPECIAL   = 8'hA1;
   localparam logic [7:0] LEAD_STANDARD  = 8'hA4;
   localparam logic [7:0] TRAIL_LO_FIRST = 8'h40;
   localparam logic [7:0] TRAIL_LO_LAST  = 8'h7E;
   localparam logic [7:0] TRAIL_HI_FIRST = 8'hA1;
   localparam logic [7:0] TRAIL_HI_LAST  = 8'hFE;
   localparam logic [7:0] TRAIL_HI_BASE  = 8'd63;
   localparam int unsigned TRAILS_PER_ROW = 157;

   // Configuration register indexes
   localparam logic [1:0] CSR_ORIGIN_X   = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y   = 2'd1;
   localparam logic [1:0] CSR_CHAR_SPAN  = 2'd2;
   localparam logic [1:0] CSR_LINE_SPACE = 2'd3;

   localparam logic [7:0] SPAN_RESET = 8'd20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  font_select;
      logic [18:0] glyph_offset;
      logic [4:0]  glyph_bytes;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        bad_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [7:0]  char_span;
      logic [7:0]  line_space;
   } cfg_type;

   // One glyph in flight between the cursor stage and the address stage
   typedef struct packed {
      logic        is_wide;
      logic [7:0]  lead;
      logic [7:0]  code;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
   } glyph_type;

endpackage

FILE: rtl/core/big5gf_front.sv
// Byte decode, pending lead byte, cursor tracking and glyph stage register.
module big5gf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  big5gf_pkg::req_type   req_data,
   input  big5gf_pkg::cfg_type   cfg,
   input  logic                  out_open,
   output logic                  glyph_valid,
   output big5gf_pkg::glyph_type glyph
);
   import big5gf_pkg::*;

   logic        lead_pending_ff, lead_pending_in;
   logic [7:0]  lead_byte_ff, lead_byte_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic        glyph_valid_ff, glyph_valid_in;
   glyph_type   glyph_ff, glyph_in;

   logic        accept;
   logic        emit;
   logic [15:0] cur_x, cur_y;
   logic        pend;
   logic [7:0]  b;

   // Stage takes a new byte when empty or when its glyph moves on
   assign req_stall = glyph_valid_ff && !out_open;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.text_byte;

   // Decode one byte against the cursor and pending lead state
   always_comb begin
      cur_x           = req_data.start_text ? cfg.origin_x : cursor_x_ff;
      cur_y           = req_data.start_text ? cfg.origin_y : cursor_y_ff;
      pend            = req_data.start_text ? 1'b0 : lead_pending_ff;
      lead_pending_in = pend;
      lead_byte_in    = lead_byte_ff;
      cursor_x_in     = cur_x;
      cursor_y_in     = cur_y;
      emit            = 1'b0;
      glyph_in        = '{is_wide: pend, lead: lead_byte_ff, code: b,
                          pos_x: cur_x, pos_y: cur_y};
      if (b == BYTE_NUL) begin
         lead_pending_in = 1'b0;
      end else if (pend) begin
         lead_pending_in = 1'b0;
         emit            = 1'b1;
      end else if (b >= LEAD_FIRST) begin
         lead_byte_in    = b;
         lead_pending_in = 1'b1;
      end else if (b >= BYTE_HIGH_CTRL) begin
         lead_pending_in = 1'b0;
      end else if (b == BYTE_NEWLINE) begin
         cursor_x_in = cfg.origin_x;
         cursor_y_in = cur_y + {8'd0, cfg.line_space};
      end else begin
         emit = 1'b1;
      end
      if (emit) begin
         cursor_x_in = cur_x + {8'd0, cfg.char_span};
      end
   end

   // Advance or hold the glyph stage
   always_comb begin
      glyph_valid_in = glyph_valid_ff;
      if (glyph_valid_ff && out_open) begin
         glyph_valid_in = 1'b0;
      end
      if (accept) begin
         glyph_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= 8'd0;
         cursor_x_ff     <= 16'd0;
         cursor_y_ff     <= 16'd0;
         glyph_valid_ff  <= 1'b0;
      end else begin
         glyph_valid_ff <= glyph_valid_in;
         if (accept) begin
            lead_pending_ff <= lead_pending_in;
            lead_byte_ff    <= lead_byte_in;
            cursor_x_ff     <= cursor_x_in;
            cursor_y_ff     <= cursor_y_in;
         end
      end
   end

   // Capture glyph payload on transfer
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         glyph_ff <= glyph_in;
      end
   end

   assign glyph_valid = glyph_valid_ff;
   assign glyph       = glyph_ff;

endmodule

FILE: rtl/core/big5gf_addr.sv
// Glyph bitmap offset computation and result register.
module big5gf_addr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  glyph_valid,
   input  big5gf_pkg::glyph_type glyph,
   output logic                  out_open,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output big5gf_pkg::rsp_type   rsp_data
);
   import big5gf_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        trail_lo, trail_hi, code_ok;
   logic        standard;
   logic [7:0]  idx;
   logic [7:0]  row_full;
   logic [6:0]  row;
   logic [14:0] linear;
   logic [18:0] wide_offset;
   logic [18:0] ascii_offset;

   // Result register frees up when empty or when its result is taken
   assign out_open = !rsp_valid_ff || !rsp_stall;

   // Trail index, code row and bitmap offsets
   always_comb begin
      trail_lo = (glyph.code >= TRAIL_LO_FIRST) && (glyph.code <= TRAIL_LO_LAST);
      trail_hi = (glyph.code >= TRAIL_HI_FIRST) && (glyph.code <= TRAIL_HI_LAST);
      if (trail_lo) begin
         idx = glyph.code - TRAIL_LO_FIRST;
      end else begin
         idx = glyph.code - TRAIL_HI_FIRST + TRAIL_HI_BASE;
      end
      standard = glyph.lead >= LEAD_STANDARD;
      row_full = glyph.lead - (standard ? LEAD_STANDARD : LEAD_SPECIAL);
      row      = row_full[6:0];
      code_ok  = (trail_lo || trail_hi) && (glyph.lead >= LEAD_SPECIAL);
      linear   = 15'(row) * 15'(TRAILS_PER_ROW) + 15'(idx);
      wide_offset  = 19'(linear) * 19'(WIDE_BYTES);
      ascii_offset = 19'(glyph.code) * 19'(ASCII_BYTES);
   end

   // Assemble the fetch command
   always_comb begin
      rsp_data_in.pos_x = glyph.pos_x;
      rsp_data_in.pos_y = glyph.pos_y;
      if (glyph.is_wide) begin
         rsp_data_in.font_select  = standard ? FONT_STANDARD : FONT_SPECIAL;
         rsp_data_in.glyph_offset = code_ok ? wide_offset : 19'd0;
         rsp_data_in.glyph_bytes  = WIDE_BYTES;
         rsp_data_in.bad_code     = !code_ok;
      end else begin
         rsp_data_in.font_select  = FONT_ASCII;
         rsp_data_in.glyph_offset = ascii_offset;
         rsp_data_in.glyph_bytes  = ASCII_BYTES;
         rsp_data_in.bad_code     = 1'b0;
      end
   end

   assign rsp_valid_in = out_open ? glyph_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load a new result on transfer from the glyph stage
   always_ff @(posedge clock) begin
      if (out_open && glyph_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/big5_glyph_fetch_sequencer.sv
// Big5 glyph fetch sequencer: one text byte per cycle while req_stall is low,
// one fetch command per glyph, registered in the glyph stage, then the result register.
// Throughput: one byte per cycle unless stalled; cursor and lead byte update on transfer.
// The glyph stage and the result register form a two-entry pipeline with stall.
// Reset (synchronous): cursor and origins to 0, spans to 20, no lead pending, pipe empty.
module big5_glyph_fetch_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  big5gf_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output big5gf_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import big5gf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      out_open;
   logic      glyph_valid;
   glyph_type glyph;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata;
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata;
            CSR_CHAR_SPAN:  cfg_in.char_span  = csr_wdata[7:0];
            CSR_LINE_SPACE: cfg_in.line_space = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: 16'd0, origin_y: 16'd0,
                     char_span: SPAN_RESET, line_space: SPAN_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   big5gf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .out_open    (out_open),
      .glyph_valid (glyph_valid),
      .glyph       (glyph)
   );

   big5gf_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .glyph_valid (glyph_valid),
      .glyph       (glyph),
      .out_open    (out_open),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // Input stalls only when both pipeline entries are full and output is stalled
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && glyph_valid))
      else $error("input stalled while pipeline has room");

   // Bitmap length follows the font
   a_len_matches_font: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.font_select == FONT_ASCII) ==
                     (rsp_data.glyph_bytes == ASCII_BYTES)))
      else $error("glyph length does not match font");

   // Invalid double-byte codes carry a zero offset
   a_bad_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_code) |->
         (rsp_data.glyph_offset == 19'd0 && rsp_data.font_select != FONT_ASCII))
      else $error("bad code with nonzero offset or ascii font");

   // A waiting glyph reaches the output once the result register opens
   a_glyph_moves: assert property (@(posedge clock) disable iff (reset)
      (glyph_valid && !rsp_valid) |=> rsp_valid)
      else $error("glyph not moved into empty result register");

endmodule
